// File: design/alpha_composite_over_core_assert.svh
// Assertion macros shared by the alpha compositing core.
// Expects i_clk and i_rst_n (active low) in the including module.
`ifndef ALPHA_COMPOSITE_OVER_CORE_ASSERT_SVH
`define ALPHA_COMPOSITE_OVER_CORE_ASSERT_SVH

// property checked every cycle outside reset
`define ACOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ACOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/acoc_pkg.sv
// Shared constants for the alpha compositing core.
// No dependencies.
package acoc_pkg;

    localparam int unsigned DEF_CHANNEL_BITS = 8;
    localparam int unsigned N_SLOTS          = 4;   // alpha, blue, green, red
    localparam int unsigned ALPHA_SLOT       = 0;
    localparam int unsigned PIXEL_BITS       = 32;

endpackage

// File: design/acoc_front.sv
// Front end: two register stages forming the blend weight and the three colour numerators.
// Depends on acoc_pkg and alpha_composite_over_core_assert.svh.
`include "alpha_composite_over_core_assert.svh"

module acoc_front
    import acoc_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [N_SLOTS*CHANNEL_BITS-1:0]           i_dst,
    input  logic [N_SLOTS*CHANNEL_BITS-1:0]           i_src,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [2*CHANNEL_BITS-1:0]                 o_den,
    output logic [N_SLOTS-1:0][3*CHANNEL_BITS-1:0]    o_num
);

    localparam int unsigned W  = CHANNEL_BITS;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned NW = 3 * W;
    localparam logic [W-1:0] CH_MAX = {W{1'b1}};

    // stage 1
    logic                           r_v1;
    logic [DW-1:0]                  r_den1;
    logic [W-1:0]                   r_inv;
    logic [N_SLOTS-1:1][DW-1:0]     r_ps;
    logic [N_SLOTS-1:1][DW-1:0]     r_pd;
    // stage 2
    logic                           r_v2;
    logic [DW-1:0]                  r_den2;
    logic [N_SLOTS-1:0][NW-1:0]     r_num;

    logic                           w_rdy1;
    logic                           w_rdy2;
    logic [W-1:0]                   w_sa;
    logic [W-1:0]                   w_da;
    logic [W-1:0]                   n_inv;
    logic [DW-1:0]                  n_den;
    logic [N_SLOTS-1:1][DW-1:0]     n_ps;
    logic [N_SLOTS-1:1][DW-1:0]     n_pd;
    logic [N_SLOTS-1:0][NW-1:0]     n_num;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_den   = r_den2;
    assign o_num   = r_num;

    assign w_sa  = i_src[ALPHA_SLOT*W +: W];
    assign w_da  = i_dst[ALPHA_SLOT*W +: W];
    assign n_inv = CH_MAX - w_sa;
    // den = sa*M + da*(M - sa); sa*M done as shift and subtract
    assign n_den = ({w_sa, {W{1'b0}}} - DW'(w_sa)) + DW'(w_da) * DW'(n_inv);

    always_comb begin
        for (int s = 1; s < N_SLOTS; s++) begin
            n_ps[s] = DW'(i_src[s*W +: W]) * DW'(w_sa);
            n_pd[s] = DW'(i_dst[s*W +: W]) * DW'(w_da);
        end
    end

    always_comb begin
        // alpha lane divides den by M
        n_num[ALPHA_SLOT] = NW'(r_den1);
        for (int s = 1; s < N_SLOTS; s++) begin
            n_num[s] = ({r_ps[s], {W{1'b0}}} - NW'(r_ps[s])) + NW'(r_pd[s]) * NW'(r_inv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r_den1 <= n_den;
            r_inv  <= n_inv;
            r_ps   <= n_ps;
            r_pd   <= n_pd;
        end
        if (r_v1 && w_rdy2) begin
            r_den2 <= r_den1;
            r_num  <= n_num;
        end
    end

    // colour numerator never exceeds M*den, so each quotient fits a channel
    for (genvar g = 1; g < N_SLOTS; g++) begin : g_chk
        `ACOC_ASSERT(a_num_bound, r_v2 |-> (r_num[g] <= ({r_den2, {W{1'b0}}} - NW'(r_den2))), "colour numerator above M*den")
    end

endmodule

// File: design/acoc_div_cell.sv
// One cell of the divider chain: settles quotient bit BIT for all four lanes.
// Depends on acoc_pkg and alpha_composite_over_core_assert.svh.
`include "alpha_composite_over_core_assert.svh"

module acoc_div_cell
    import acoc_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int unsigned BIT          = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [2*CHANNEL_BITS-1:0]                 i_den,
    input  logic [N_SLOTS-1:0][3*CHANNEL_BITS-1:0]    i_rem,
    input  logic [N_SLOTS-1:0][CHANNEL_BITS-1:0]      i_quo,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [2*CHANNEL_BITS-1:0]                 o_den,
    output logic [N_SLOTS-1:0][3*CHANNEL_BITS-1:0]    o_rem,
    output logic [N_SLOTS-1:0][CHANNEL_BITS-1:0]      o_quo
);

    localparam int unsigned W  = CHANNEL_BITS;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned NW = 3 * W;
    localparam logic [NW-1:0] DIV_M = NW'({W{1'b1}});

    logic                           r_valid;
    logic [DW-1:0]                  r_den;
    logic [N_SLOTS-1:0][NW-1:0]     r_rem;
    logic [N_SLOTS-1:0][W-1:0]      r_quo;

    logic                           w_rdy;
    logic [N_SLOTS-1:0][NW-1:0]     n_rem;
    logic [N_SLOTS-1:0][W-1:0]      n_quo;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

    // restoring step; lanes are independent
    always_comb begin
        logic [NW-1:0] dv;
        logic [NW-1:0] sh;
        for (int l = 0; l < N_SLOTS; l++) begin
            dv = (l == ALPHA_SLOT) ? DIV_M : NW'(i_den);
            sh = dv << BIT;
            if (i_rem[l] >= sh) begin
                n_rem[l] = i_rem[l] - sh;
                n_quo[l] = i_quo[l] | (W'(1) << BIT);
            end else begin
                n_rem[l] = i_rem[l];
                n_quo[l] = i_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    `ACOC_ASSERT_NEXT(a_hold, r_valid && !i_ready, r_valid && $stable(r_rem) && $stable(r_quo), "cell lost a stalled request")

    `ACOC_ASSERT(a_alpha_rem, r_valid |-> (r_rem[ALPHA_SLOT] < (DIV_M << BIT)), "alpha remainder not reduced")

    for (genvar g = 1; g < N_SLOTS; g++) begin : g_chk
        `ACOC_ASSERT(a_rem_bound, r_valid && (r_den != '0) |-> (r_rem[g] < (NW'(r_den) << BIT)), "colour remainder not reduced")
    end

endmodule

// File: design/alpha_composite_over_core.sv
// Source-over compositing of straight-alpha RGBA pixels.
// Pipeline: two product stages, then one divider cell per quotient bit.
// Throughput: one pixel per cycle while the output accepts, set by the cell chain.
// Each stage advances when its successor is empty or moving, so bubbles are absorbed.
// Reset clears the valid flags only; no clearing pass.
`include "alpha_composite_over_core_assert.svh"

module alpha_composite_over_core
    import acoc_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [2*PIXEL_BITS-1:0] i_s_axis_tdata,   // dst_pixel [31:0], src_pixel [63:32]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [PIXEL_BITS-1:0]  o_m_axis_tdata     // out_pixel [31:0]
);

    localparam int unsigned W  = CHANNEL_BITS;
    localparam int unsigned PW = N_SLOTS * W;
    localparam int unsigned DW = 2 * W;
    localparam int unsigned NW = 3 * W;

    logic [PW-1:0]                  w_dst;
    logic [PW-1:0]                  w_src;
    logic [PW-1:0]                  w_pix;

    logic                           c_valid [W+1];
    logic                           c_ready [W+1];
    logic [DW-1:0]                  c_den   [W+1];
    logic [N_SLOTS-1:0][NW-1:0]     c_rem   [W+1];
    logic [N_SLOTS-1:0][W-1:0]      c_quo   [W+1];

    // channels beyond the 32-bit field read as zero, spare bits are dropped
    assign w_dst = PW'(i_s_axis_tdata[PIXEL_BITS-1:0]);
    assign w_src = PW'(i_s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]);

    acoc_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_dst   (w_dst),
        .i_src   (w_src),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_den   (c_den[0]),
        .o_num   (c_rem[0])
    );

    assign c_quo[0] = '0;

    // cell k settles quotient bit W-1-k
    for (genvar k = 0; k < W; k++) begin : g_cell
        acoc_div_cell #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .BIT          (W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_den   (c_den[k]),
            .i_rem   (c_rem[k]),
            .i_quo   (c_quo[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quo   (c_quo[k+1])
        );
    end

    assign c_ready[W] = i_m_axis_tready;

    // zero combined weight gives the transparent pixel
    assign w_pix           = (c_den[W] == '0) ? '0 : PW'(c_quo[W]);
    assign o_m_axis_tvalid = c_valid[W];
    assign o_m_axis_tdata  = PIXEL_BITS'(w_pix);

    // any non-zero weight yields alpha of at least one
    `ACOC_ASSERT(a_alpha_zero, o_m_axis_tvalid && (c_quo[W][ALPHA_SLOT] == '0) |-> (w_pix == '0), "zero alpha with colour set")

    `ACOC_ASSERT(a_den_zero, o_m_axis_tvalid && (c_den[W] == '0) |-> (c_quo[W][ALPHA_SLOT] == '0), "alpha set with zero weight")

endmodule

// File: bench/tb_alpha_composite_over_core.sv
// Self-checking bench for alpha_composite_over_core: source-over blending of straight alpha.
// Depends on acoc_pkg and the core; every request's result is typed in or predicted in-bench and checked in order.
module tb_alpha_composite_over_core
    import acoc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned      CH          = DEF_CHANNEL_BITS;
    localparam longint unsigned  CH_MAX      = (64'd1 << CH) - 64'd1;
    localparam int               LATENCY     = CH + 2;
    localparam int               STALL_LIMIT = 2000;
    localparam int               PER_PHASE   = 263;
    localparam int               N_DIRECTED  = 20;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] dst;
        logic [PIXEL_BITS-1:0] src;
        logic [PIXEL_BITS-1:0] want;
        logic                  fixed;   // want typed in, else predicted
    } t_over_case;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [2*PIXEL_BITS-1:0] i_s_axis_tdata  = '0;  // dst_pixel [31:0], src_pixel [63:32]
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [PIXEL_BITS-1:0]   o_m_axis_tdata;        // out_pixel [31:0]

    logic [PIXEL_BITS-1:0] pending_pixels [$];
    int                    mismatch_count = 0;
    int                    feed_idle_pct  = 0;
    int                    drain_stall_pct = 0;

    t_over_case directed_cases [N_DIRECTED] = '{
        '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1},  // all zero
        '{32'hFFFFFF00, 32'hFFFFFF00, 32'h00000000, 1'b1},  // both transparent
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
        '{32'h12345678, 32'h9ABCDEFF, 32'h9ABCDEFF, 1'b1},  // opaque source wins
        '{32'h13579BFF, 32'h2468AC00, 32'h13579BFF, 1'b1},  // clear source keeps dst
        '{32'hA1B2C380, 32'h00000000, 32'hA1B2C380, 1'b1},
        '{32'h00000000, 32'hFFFFFF01, 32'hFFFFFF01, 1'b1},
        '{32'hFFFFFF00, 32'h000000FF, 32'h000000FF, 1'b1},
        '{32'h00000001, 32'h00000000, 32'h00000001, 1'b1},
        '{32'h00000000, 32'h000000FF, 32'h000000FF, 1'b1},
        '{32'hFFFFFFFF, 32'hFFFFFF00, 32'hFFFFFFFF, 1'b1},
        '{32'hFFFFFF01, 32'h00000001, 32'h0,        1'b0},  // faintest alphas
        '{32'hFFFFFFFF, 32'h00000080, 32'h0,        1'b0},
        '{32'h000000FF, 32'hFFFFFF80, 32'h0,        1'b0},
        '{32'h00FF00FE, 32'hFF00FF01, 32'h0,        1'b0},
        '{32'hFF00FF7F, 32'h00FF0080, 32'h0,        1'b0},
        '{32'hFFFFFFFE, 32'hFFFFFFFE, 32'h0,        1'b0},  // clamp guard territory
        '{32'h80808080, 32'h7F7F7F7F, 32'h0,        1'b0},
        '{32'h01010101, 32'hFEFEFEFE, 32'h0,        1'b0},
        '{32'h55AA55C0, 32'hAA55AA40, 32'h0,        1'b0}
    };

    alpha_composite_over_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // exact rational source-over, truncated per channel
    function automatic logic [PIXEL_BITS-1:0] composite_over(logic [PIXEL_BITS-1:0] dst,
                                                             logic [PIXEL_BITS-1:0] src);
        longint unsigned sa, da, den, sc, dc, q;
        longint unsigned pix;
        pix = 0;
        sa  = longint'(src) & CH_MAX;
        da  = longint'(dst) & CH_MAX;
        den = sa * CH_MAX + da * (CH_MAX - sa);
        if (den == 0) begin
            return '0;
        end
        for (int k = 1; k < N_SLOTS; k++) begin
            sc = (longint'(src) >> (k * CH)) & CH_MAX;
            dc = (longint'(dst) >> (k * CH)) & CH_MAX;
            q  = (sc * sa * CH_MAX + dc * da * (CH_MAX - sa)) / den;
            if (q > CH_MAX) begin
                q = CH_MAX;
            end
            pix |= q << (k * CH);
        end
        q = den / CH_MAX;
        if (q > CH_MAX) begin
            q = CH_MAX;
        end
        pix |= q;
        return pix[PIXEL_BITS-1:0];
    endfunction

    // biased towards the alpha corners where the blend weights degenerate
    function automatic logic [CH-1:0] pick_alpha();
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return CH_MAX[CH-1:0];
            end
            2: begin
                return CH'(1);
            end
            3: begin
                return CH_MAX[CH-1:0] - 1'b1;
            end
            default: begin
                return CH'($urandom_range(32'(CH_MAX)));
            end
        endcase
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        logic [PIXEL_BITS-1:0] pix;
        pix = $urandom;
        case ($urandom_range(7))
            0: begin
                pix = '0;
            end
            1: begin
                pix = '1;
            end
            default: begin
            end
        endcase
        pix[CH-1:0] = pick_alpha();
        return pix;
    endfunction

    task automatic report_mismatch(string what, logic [PIXEL_BITS-1:0] got,
                                   logic [PIXEL_BITS-1:0] want);
        $display("MISMATCH %s: got %08h want %08h", what, got, want);
        mismatch_count++;
    endtask

    // one request: random idle gap, then hold valid until the core takes it
    task automatic send_pixel(logic [PIXEL_BITS-1:0] dst, logic [PIXEL_BITS-1:0] src,
                              logic [PIXEL_BITS-1:0] want);
        while ($urandom_range(99) < feed_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {src, dst};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pending_pixels.push_back(want);
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= drain_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("out_pixel with nothing pending", o_m_axis_tdata, '0);
            end else if (o_m_axis_tdata !== pending_pixels[0]) begin
                report_mismatch("out_pixel", o_m_axis_tdata, pending_pixels[0]);
                void'(pending_pixels.pop_front());
            end else begin
                void'(pending_pixels.pop_front());
            end
        end
    end

    // ends the run if neither side moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        logic [PIXEL_BITS-1:0] dst, src;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_cases[i]) begin
            send_pixel(directed_cases[i].dst, directed_cases[i].src,
                       directed_cases[i].fixed ? directed_cases[i].want :
                       composite_over(directed_cases[i].dst, directed_cases[i].src));
        end

        // phases: free flow, idle feed, stalled drain, both
        for (int phase = 0; phase < 4; phase++) begin
            feed_idle_pct   = (phase == 1) ? 62 : (phase == 3) ? 21 : 0;
            drain_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 21 : 0;
            for (int n = 0; n < PER_PHASE; n++) begin
                dst = pick_pixel();
                src = pick_pixel();
                if ($urandom_range(19) == 0) begin
                    dst[CH-1:0] = '0;
                    src[CH-1:0] = '0;
                end
                send_pixel(dst, src, composite_over(dst, src));
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray extra result
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/acoc_pkg.sv
design/acoc_front.sv
design/acoc_div_cell.sv
design/alpha_composite_over_core.sv
bench/tb_alpha_composite_over_core.sv
